### hw/rtl/sff_pkg.sv
// shared types, register map and constants of the stereo feedback flanger
`timescale 1ns / 1ps

package sff_pkg;

  // default structure of the unit
  localparam int DELAY_DEPTH_DEF = 2048;
  localparam int UPSAMPLE_DEF    = 4;
  localparam int LINE_WIDTH_DEF  = 20;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MIX_GAIN      = 3'd0,
    REG_BASE_DELAY    = 3'd1,
    REG_SWEEP_STEP    = 3'd2,
    REG_LFO_PERIOD    = 3'd3,
    REG_WARMUP_POINTS = 3'd4
  } sff_reg_t;

  localparam logic [15:0] MIX_GAIN_RST      = 16'd49152;
  localparam logic [10:0] BASE_DELAY_RST    = 11'd882;
  localparam logic [15:0] SWEEP_STEP_RST    = 16'd459;
  localparam logic [19:0] LFO_PERIOD_RST    = 20'd252000;
  localparam logic [19:0] WARMUP_POINTS_RST = 20'd7056;

  // interpolation: floor(n / UPSAMPLE) as (n * recip) >> RECIP_SHIFT, n below 2^INTERP_N_W
  localparam int INTERP_N_W  = 23;
  localparam int INTERP_OFS  = 19;
  localparam int RECIP_SHIFT = 26;
  // signed operand widths of the shared multiplier
  localparam int COEF_W      = 28;
  localparam int DATA_MIN_W  = 24;

  typedef enum logic [1:0] {
    MUL_SWEEP    = 2'd0,
    MUL_INTERP   = 2'd1,
    MUL_FEEDBACK = 2'd2
  } sff_mul_op_t;

  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } sff_in_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               clipped;
  } sff_out_t;

endpackage

### hw/rtl/sff_chan_if.sv
// valid/ready channel carrying one payload item
`timescale 1ns / 1ps

interface sff_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/sff_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module sff_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata_r
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end
endmodule

### hw/rtl/sff_mul.sv
// shared signed multiplier with operand selection and registered product
`timescale 1ns / 1ps

module sff_mul #(
  parameter int LINE_WIDTH = 20,
  parameter int UPSAMPLE   = 4,
  localparam int DATA_W = (LINE_WIDTH > sff_pkg::DATA_MIN_W) ? LINE_WIDTH : sff_pkg::DATA_MIN_W,
  localparam int PROD_W = DATA_W + sff_pkg::COEF_W
) (
  input  logic                                clk,
  input  sff_pkg::sff_mul_op_t                op,
  input  logic [19:0]                         tri_val,
  input  logic [15:0]                         step,
  input  logic [15:0]                         mix,
  input  logic [sff_pkg::INTERP_N_W-1:0]      interp,
  input  logic signed [LINE_WIDTH-1:0]        delayed,
  output logic signed [PROD_W-1:0]            prod_r
);
  import sff_pkg::*;

  localparam logic [COEF_W-1:0] RECIP =
    COEF_W'(((64'd1 << RECIP_SHIFT) + 64'(UPSAMPLE) - 64'd1) / 64'(UPSAMPLE));

  logic signed [DATA_W-1:0] a_op;
  logic signed [COEF_W-1:0] b_op;

  always_comb begin
    unique case (op)
      MUL_SWEEP: begin
        a_op = signed'(DATA_W'(tri_val));
        b_op = signed'(COEF_W'(step));
      end
      MUL_INTERP: begin
        a_op = signed'(DATA_W'(interp));
        b_op = signed'(RECIP);
      end
      MUL_FEEDBACK: begin
        a_op = DATA_W'(delayed);
        b_op = signed'(COEF_W'(mix));
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= a_op * b_op;
  end
endmodule

### hw/rtl/stereo_feedback_flanger_unit.sv
// stereo feedback flanger: sequencer, delay line and shared multiplier
`timescale 1ns / 1ps

//  channel   | dir | handshake           | payload
//  in_chan   | in  | valid/ready         | left_in, right_in (s16)
//  out_chan  | out | valid/ready         | left_out, right_out (s16), clipped
//  cfg_*     | in  | write enable only   | cfg_addr register index, cfg_wdata value
//
//  each item runs six steps per interpolated point, all of them sharing one multiplier
//  (sweep, two interpolations, two feedback products), plus the accept cycle and the
//  hand-over to the output register
//  in_chan.ready is high only while the sequencer is idle
//  the result register holds its item while out_chan stalls; a finished item waits in the
//  last step until that register is free; reset (synchronous, active low) restores the
//  registers and clears counters; the delay line is not cleared, the user must see that
//  it is only read back after it has been written; the block itself does not enforce it

module stereo_feedback_flanger_unit #(
  parameter int DELAY_DEPTH = sff_pkg::DELAY_DEPTH_DEF,
  parameter int UPSAMPLE    = sff_pkg::UPSAMPLE_DEF,
  parameter int LINE_WIDTH  = sff_pkg::LINE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sff_chan_if.sink                          in_chan,
  sff_chan_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [sff_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [sff_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import sff_pkg::*;

  localparam int IW     = $clog2(DELAY_DEPTH);
  localparam int PT_W   = (UPSAMPLE > 1) ? $clog2(UPSAMPLE) : 1;
  localparam int DATA_W = (LINE_WIDTH > DATA_MIN_W) ? LINE_WIDTH : DATA_MIN_W;
  localparam int PROD_W = DATA_W + COEF_W;
  localparam int LW     = LINE_WIDTH;

  localparam logic signed [LW-1:0] S16_MAX = LW'(32767);
  localparam logic signed [LW-1:0] S16_MIN = -LW'(32768);

  // per-point sequence: sweep, delay, address, left feedback, right feedback, write
  typedef enum logic [2:0] {
    S_IDLE, S_TRI, S_DLY, S_ADR, S_FBL, S_FBR, S_WR, S_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic [15:0] mix_gain_r;
  logic [10:0] base_delay_r;
  logic [15:0] sweep_step_r;
  logic [19:0] lfo_period_r;
  logic [19:0] warmup_points_r;

  // running state
  logic signed [15:0] prev_l_r, prev_r_r;
  logic signed [15:0] cur_l_r, cur_r_r;
  logic signed [16:0] diff_l_r, diff_r_r;
  logic signed [19:0] num_l_r, num_r_r;
  logic [19:0]        phase_r;
  logic [19:0]        count_r;
  logic [IW-1:0]      wi_r;
  logic [IW-1:0]      d_r;
  logic [PT_W-1:0]    pt_r;
  logic signed [LW-1:0] xl_r, xr_r, yl_r, yr_r;

  logic     out_valid_r;
  sff_out_t out_data_r;

  // shared multiplier
  sff_mul_op_t             mul_op;
  logic signed [PROD_W-1:0] prod_r;
  logic [INTERP_N_W-1:0]   interp_n;
  logic signed [LW-1:0]    delayed;

  // delay line, left in the upper half and right in the lower
  logic [2*LW-1:0] ram_rdata_r;
  logic [2*LW-1:0] ram_wdata;
  logic [IW-1:0]   rd_addr;
  logic            ram_re, ram_we;

  // combinational helpers
  logic [19:0]          tri_w;
  logic [19:0]          phase_gap;
  logic [37:0]          sweep_sum;
  logic [21:0]          d_sum;
  logic [IW-1:0]        d_clamped;
  logic [IW:0]          rd_wide;
  logic [INTERP_N_W:0]  n_l, n_r;
  logic signed [23:0]   x_w;
  logic signed [LW-1:0] fb_w;
  logic signed [LW:0]   fb_sum;
  logic signed [LW-1:0] y_fb;
  logic                 warm;
  logic                 last_pt;
  logic [20:0]          phase_inc;
  logic                 sat_l_hi, sat_l_lo, sat_r_hi, sat_r_lo;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  assign warm    = (count_r < warmup_points_r);
  assign last_pt = (pt_r == PT_W'(UPSAMPLE - 1));

  // triangle: distance of the phase from the nearer end, zero past the period
  assign phase_gap = lfo_period_r - phase_r;
  always_comb begin
    if (phase_r < lfo_period_r) begin
      tri_w = (phase_r < phase_gap) ? phase_r : phase_gap;
    end else begin
      tri_w = '0;
    end
  end

  // delay = base + ceil(tri * step / 2^16), clamped to the line
  assign sweep_sum = prod_r[37:0] + 38'd65535;
  assign d_sum     = 22'(base_delay_r) + 22'(sweep_sum[36:16]);
  always_comb begin
    if (d_sum > 22'(DELAY_DEPTH - 1)) begin
      d_clamped = IW'(DELAY_DEPTH - 1);
    end else if (d_sum == '0) begin
      d_clamped = IW'(1);
    end else begin
      d_clamped = d_sum[IW-1:0];
    end
  end

  always_comb begin
    if (wi_r >= d_r) begin
      rd_wide = {1'b0, wi_r} - {1'b0, d_r};
    end else begin
      rd_wide = {1'b0, wi_r} + (IW+1)'(DELAY_DEPTH) - {1'b0, d_r};
    end
  end
  assign rd_addr = rd_wide[IW-1:0];

  // offset numerator so the reciprocal product sees a non-negative value
  assign n_l = (INTERP_N_W+1)'(num_l_r) + (INTERP_N_W+1)'(UPSAMPLE << INTERP_OFS);
  assign n_r = (INTERP_N_W+1)'(num_r_r) + (INTERP_N_W+1)'(UPSAMPLE << INTERP_OFS);

  // point = prev + floor(num / UPSAMPLE)
  always_comb begin
    if (state_r == S_ADR) begin
      x_w = 24'(prev_l_r) + signed'({1'b0, prod_r[RECIP_SHIFT +: INTERP_N_W]})
            - 24'sd524288;
    end else begin
      x_w = 24'(prev_r_r) + signed'({1'b0, prod_r[RECIP_SHIFT +: INTERP_N_W]})
            - 24'sd524288;
    end
  end

  // y = x + floor(mix * delayed / 2^16), saturated to the line width
  assign fb_w = prod_r[16 +: LW];
  always_comb begin
    if (state_r == S_FBR) begin
      fb_sum = (LW+1)'(xl_r) + (LW+1)'(fb_w);
    end else begin
      fb_sum = (LW+1)'(xr_r) + (LW+1)'(fb_w);
    end
    if (fb_sum[LW] != fb_sum[LW-1]) begin
      y_fb = fb_sum[LW] ? {1'b1, {(LW-1){1'b0}}} : {1'b0, {(LW-1){1'b1}}};
    end else begin
      y_fb = fb_sum[LW-1:0];
    end
  end

  always_comb begin
    unique case (state_r) inside
      S_TRI:          mul_op = MUL_SWEEP;
      S_DLY, S_ADR:   mul_op = MUL_INTERP;
      default:        mul_op = MUL_FEEDBACK;
    endcase
  end

  assign interp_n = (state_r == S_DLY) ? n_l[INTERP_N_W-1:0] : n_r[INTERP_N_W-1:0];
  assign delayed  = (state_r == S_FBL) ? signed'(ram_rdata_r[2*LW-1:LW])
                                       : signed'(ram_rdata_r[LW-1:0]);

  assign ram_re    = (state_r == S_ADR);
  assign ram_we    = (state_r == S_WR);
  assign ram_wdata = {yl_r, (warm ? xr_r : y_fb)};

  assign phase_inc = {1'b0, phase_r} + 21'd1;

  assign sat_l_hi = (yl_r > S16_MAX);
  assign sat_l_lo = (yl_r < S16_MIN);
  assign sat_r_hi = (yr_r > S16_MAX);
  assign sat_r_lo = (yr_r < S16_MIN);

  sff_mul #(
    .LINE_WIDTH (LINE_WIDTH),
    .UPSAMPLE   (UPSAMPLE)
  ) u_mul (
    .clk     (clk),
    .op      (mul_op),
    .tri_val (tri_w),
    .step    (sweep_step_r),
    .mix     (mix_gain_r),
    .interp  (interp_n),
    .delayed (delayed),
    .prod_r  (prod_r)
  );

  sff_ram #(
    .WIDTH (2 * LW),
    .DEPTH (DELAY_DEPTH)
  ) u_line (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (wi_r),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (rd_addr),
    .rdata_r (ram_rdata_r)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_gain_r      <= MIX_GAIN_RST;
      base_delay_r    <= BASE_DELAY_RST;
      sweep_step_r    <= SWEEP_STEP_RST;
      lfo_period_r    <= LFO_PERIOD_RST;
      warmup_points_r <= WARMUP_POINTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIX_GAIN:      mix_gain_r      <= cfg_wdata[15:0];
        REG_BASE_DELAY:    base_delay_r    <= cfg_wdata[10:0];
        REG_SWEEP_STEP:    sweep_step_r    <= cfg_wdata[15:0];
        REG_LFO_PERIOD:    lfo_period_r    <= cfg_wdata[19:0];
        REG_WARMUP_POINTS: warmup_points_r <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_l_r    <= '0;
      prev_r_r    <= '0;
      phase_r     <= '0;
      count_r     <= '0;
      wi_r        <= '0;
      pt_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result register loads from the last step and frees up when taken
      if (state_r == S_DONE && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            cur_l_r  <= in_chan.data.left_in;
            cur_r_r  <= in_chan.data.right_in;
            diff_l_r <= 17'(in_chan.data.left_in) - 17'(prev_l_r);
            diff_r_r <= 17'(in_chan.data.right_in) - 17'(prev_r_r);
            num_l_r  <= 20'(17'(in_chan.data.left_in) - 17'(prev_l_r));
            num_r_r  <= 20'(17'(in_chan.data.right_in) - 17'(prev_r_r));
            pt_r     <= '0;
            state_r  <= S_TRI;
          end
        end
        S_TRI: begin
          state_r <= S_DLY;
        end
        S_DLY: begin
          d_r     <= d_clamped;
          state_r <= S_ADR;
        end
        S_ADR: begin
          xl_r    <= LW'(x_w);
          state_r <= S_FBL;
        end
        S_FBL: begin
          xr_r    <= LW'(x_w);
          state_r <= S_FBR;
        end
        S_FBR: begin
          yl_r    <= warm ? xl_r : y_fb;
          state_r <= S_WR;
        end
        S_WR: begin
          yr_r    <= warm ? xr_r : y_fb;
          if (warm) begin
            count_r <= count_r + 20'd1;
          end
          wi_r    <= (wi_r == IW'(DELAY_DEPTH - 1)) ? '0 : wi_r + IW'(1);
          phase_r <= (phase_inc >= {1'b0, lfo_period_r}) ? '0 : phase_inc[19:0];
          num_l_r <= num_l_r + 20'(diff_l_r);
          num_r_r <= num_r_r + 20'(diff_r_r);
          pt_r    <= pt_r + PT_W'(1);
          if (last_pt) begin
            prev_l_r <= cur_l_r;
            prev_r_r <= cur_r_r;
            state_r  <= S_DONE;
          end else begin
            state_r  <= S_TRI;
          end
        end
        S_DONE: begin
          // last point's y, saturated to 16 bits
          if (!out_valid_r || out_chan.ready) begin
            out_data_r.left_out  <= sat_l_hi ? 16'sh7fff :
                                    (sat_l_lo ? 16'sh8000 : yl_r[15:0]);
            out_data_r.right_out <= sat_r_hi ? 16'sh7fff :
                                    (sat_r_lo ? 16'sh8000 : yr_r[15:0]);
            out_data_r.clipped   <= sat_l_hi | sat_l_lo | sat_r_hi | sat_r_lo;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### bench/tb_stereo_feedback_flanger_unit.sv
// self-checking bench for the stereo feedback flanger unit with its own fixed-point predictor
`timescale 1ns / 1ps

module tb_stereo_feedback_flanger_unit;
  import sff_pkg::*;

  // structure of the unit under test, kept at the package defaults
  localparam int LINE_DEPTH  = DELAY_DEPTH_DEF;
  localparam int POINTS      = UPSAMPLE_DEF;
  localparam int LINE_BITS   = LINE_WIDTH_DEF;
  localparam int IDX_BITS    = $clog2(LINE_DEPTH);
  localparam int ITEM_CYCLES = 6 * POINTS + 2;

  // cycles with no handshake on either channel before the run is called dead
  localparam int IDLE_LIMIT  = 5000;
  // length of the one long receiver hold-off, and the item count that sets it off
  localparam int HOLD_CYCLES = 700;
  localparam int HOLD_AFTER  = 300;

  // shapes of the random audio content, picked per burst
  typedef enum int {
    STYLE_UNIFORM,
    STYLE_QUIET,
    STYLE_EXTREME,
    STYLE_RAMP
  } stim_style_t;

  // ---------------------------------------------------------------------------
  // scoreboard: fixed-point flanger predictor plus a queue of expected pairs
  // ---------------------------------------------------------------------------
  class flanger_scoreboard;
    // register copies
    logic [15:0]          mix_gain;
    logic [10:0]          base_delay;
    logic [15:0]          sweep_step;
    logic [19:0]          lfo_period;
    logic [19:0]          warmup_points;
    // processing state
    logic signed [15:0]   prev_left;
    logic signed [15:0]   prev_right;
    logic signed [LINE_BITS-1:0] left_line  [LINE_DEPTH];
    logic signed [LINE_BITS-1:0] right_line [LINE_DEPTH];
    logic [20:0]          warm_count;
    logic [19:0]          lfo_phase;
    logic [IDX_BITS-1:0]  write_idx;

    sff_out_t expected_pairs[$];
    int       pairs_noted;
    int       pairs_checked;
    int       fault_count;

    function new();
      mix_gain      = MIX_GAIN_RST;
      base_delay    = BASE_DELAY_RST;
      sweep_step    = SWEEP_STEP_RST;
      lfo_period    = LFO_PERIOD_RST;
      warmup_points = WARMUP_POINTS_RST;
      prev_left     = '0;
      prev_right    = '0;
      warm_count    = '0;
      lfo_phase     = '0;
      write_idx     = '0;
      pairs_noted   = 0;
      pairs_checked = 0;
      fault_count   = 0;
      foreach (left_line[i]) begin
        left_line[i]  = '0;
        right_line[i] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MIX_GAIN:      mix_gain      = val[15:0];
        REG_BASE_DELAY:    base_delay    = val[10:0];
        REG_SWEEP_STEP:    sweep_step    = val[15:0];
        REG_LFO_PERIOD:    lfo_period    = val[19:0];
        REG_WARMUP_POINTS: warmup_points = val[19:0];
        default: ;
      endcase
    endfunction

    function longint floor_div(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q--;
      return q;
    endfunction

    function longint clamp_bits(longint v, int bits, output bit hit);
      longint hi;
      hi  = (longint'(1) << (bits - 1)) - 1;
      hit = 1'b0;
      if (v > hi) begin
        hit = 1'b1;
        return hi;
      end
      if (v < -hi - 1) begin
        hit = 1'b1;
        return -hi - 1;
      end
      return v;
    endfunction

    function sff_out_t flange_pair(sff_in_t pair);
      longint xl, xr, yl, yr, span, tri_dist, dly;
      logic [IDX_BITS-1:0] rd;
      bit hit_l, hit_r, unused_hit;
      sff_out_t res;
      yl = 0;
      yr = 0;
      for (int k = 1; k <= POINTS; k++) begin
        xl = prev_left + floor_div((longint'(pair.left_in) - prev_left) * k, POINTS);
        xr = prev_right + floor_div((longint'(pair.right_in) - prev_right) * k, POINTS);
        // triangle distance from the nearer end, zero when the phase is out of range
        tri_dist = 0;
        if (lfo_phase < lfo_period) begin
          span = longint'(lfo_period) - longint'(lfo_phase);
          tri_dist = (longint'(lfo_phase) < span) ? longint'(lfo_phase) : span;
        end
        dly = longint'(base_delay) + ((tri_dist * longint'(sweep_step) + 65535) >>> 16);
        if (dly > LINE_DEPTH - 1) dly = LINE_DEPTH - 1;
        if (dly < 1) dly = 1;
        rd = write_idx - dly[IDX_BITS-1:0];
        if (warm_count < warmup_points) begin
          yl = xl;
          yr = xr;
          warm_count++;
        end else begin
          yl = clamp_bits(xl + floor_div(longint'(mix_gain) * longint'(left_line[rd]), 65536),
                          LINE_BITS, unused_hit);
          yr = clamp_bits(xr + floor_div(longint'(mix_gain) * longint'(right_line[rd]), 65536),
                          LINE_BITS, unused_hit);
        end
        left_line[write_idx]  = yl[LINE_BITS-1:0];
        right_line[write_idx] = yr[LINE_BITS-1:0];
        write_idx++;
        lfo_phase = (longint'(lfo_phase) + 1 >= longint'(lfo_period)) ? '0 : lfo_phase + 1'b1;
      end
      prev_left  = pair.left_in;
      prev_right = pair.right_in;
      yl = clamp_bits(yl, 16, hit_l);
      yr = clamp_bits(yr, 16, hit_r);
      res.left_out  = yl[15:0];
      res.right_out = yr[15:0];
      res.clipped   = hit_l | hit_r;
      return res;
    endfunction

    function void note_input_pair(sff_in_t pair);
      expected_pairs.push_back(flange_pair(pair));
      pairs_noted++;
    endfunction

    function void check_output_pair(sff_out_t got);
      sff_out_t want;
      if (expected_pairs.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected output item L=%0d R=%0d clip=%0b",
                   got.left_out, got.right_out, got.clipped);
        return;
      end
      want = expected_pairs.pop_front();
      if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
          got.clipped !== want.clipped) begin
        fault_count++;
        if (fault_count <= 10)
          $display("mismatch on output item %0d: expected L=%0d R=%0d clip=%0b, got L=%0d R=%0d clip=%0b",
                   pairs_checked, want.left_out, want.right_out, want.clipped,
                   got.left_out, got.right_out, got.clipped);
      end
      pairs_checked++;
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset, channels and the unit
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sff_chan_if #(.payload_t(sff_in_t))  in_chan ();
  sff_chan_if #(.payload_t(sff_out_t)) out_chan ();

  flanger_scoreboard board = new();

  // running ramp values for the smooth stimulus style
  logic signed [15:0] ramp_left  = '0;
  logic signed [15:0] ramp_right = '0;

  stereo_feedback_flanger_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one audio pair in the chosen style
  function automatic sff_in_t make_pair(stim_style_t style);
    sff_in_t p;
    p = $urandom;
    case (style)
      STYLE_QUIET: begin
        p.left_in  = 16'($signed($urandom_range(0, 511)) - 256);
        p.right_in = 16'($signed($urandom_range(0, 511)) - 256);
      end
      STYLE_EXTREME: begin
        case ($urandom_range(0, 3))
          0: p.left_in = 16'sh8000;
          1: p.left_in = 16'sh7fff;
          2: p.left_in = 16'sh0000;
          default: p.left_in = 16'shffff;
        endcase
        case ($urandom_range(0, 3))
          0: p.right_in = 16'sh8000;
          1: p.right_in = 16'sh7fff;
          2: p.right_in = 16'sh0000;
          default: p.right_in = 16'shffff;
        endcase
      end
      STYLE_RAMP: begin
        // slow sawtooth, wraps through full scale now and then
        ramp_left  = ramp_left + 16'sd517;
        ramp_right = ramp_right - 16'sd389;
        p.left_in  = ramp_left;
        p.right_in = ramp_right;
      end
      default: ;
    endcase
    return p;
  endfunction

  // offer one item and hold it until the unit takes it
  task automatic send_pair(input sff_in_t pair);
    in_chan.valid <= 1'b1;
    in_chan.data  <= pair;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    board.note_input_pair(pair);
  endtask

  // random items in bursts of random length, random gaps between bursts
  task automatic run_pairs(input int count);
    int sent, burst, gap;
    stim_style_t style;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      style = stim_style_t'($urandom_range(0, 3));
      for (int b = 0; b < burst && sent < count; b++) begin
        send_pair(make_pair(style));
        sent++;
      end
      // about one burst in five runs straight into the next
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        in_chan.data  <= $urandom;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait until every expected item has come out
  task automatic drain_unit();
    in_chan.valid <= 1'b0;
    while (board.expected_pairs.size() != 0) @(posedge clk);
  endtask

  // one register write, the enable is lowered by the caller
  task automatic write_cfg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  // full register set, plus junk writes to the indexes past the map
  task automatic program_regs(input logic [CFG_DATA_W-1:0] mix, input logic [CFG_DATA_W-1:0] base,
                              input logic [CFG_DATA_W-1:0] sweep,
                              input logic [CFG_DATA_W-1:0] period,
                              input logic [CFG_DATA_W-1:0] warmup);
    write_cfg(REG_MIX_GAIN, mix);
    write_cfg(REG_BASE_DELAY, base);
    write_cfg(REG_SWEEP_STEP, sweep);
    write_cfg(REG_LFO_PERIOD, period);
    write_cfg(REG_WARMUP_POINTS, warmup);
    for (int a = int'(REG_WARMUP_POINTS) + 1; a < (1 << CFG_ADDR_W); a++)
      write_cfg(a[CFG_ADDR_W-1:0], CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern of its own, one long hold-off to back the unit up
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int  mode;
    int  mode_left;
    int  tick;
    bit  held;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    held      = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready)
        board.check_output_pair(out_chan.data);
      tick++;
      if (!held && board.pairs_noted >= HOLD_AFTER) begin
        // long hold-off while the sender keeps offering, so the input stalls too
        held = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(64, 256);
        end
        mode_left--;
        case (mode)
          0: out_chan.ready <= 1'b1;                          // no stalls at all
          1: out_chan.ready <= ($urandom_range(0, 3) != 0);   // light stalling
          2: out_chan.ready <= ($urandom_range(0, 9) < 3);    // heavy stalling
          default: out_chan.ready <= ((tick % 7) < 2);       // fixed duty pattern
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run if neither channel moves for too long
  // ---------------------------------------------------------------------------
  initial begin : idle_watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int left_vals  [16];
    int right_vals [16];
    sff_in_t pair;
    left_vals  = '{-32768, 32767, -32768, 32767, 0, -1, 1, 32767,
                   32767, -32768, -32768, 0, 12345, -12345, 32767, -32768};
    right_vals = '{32767, -32768, -32768, 32767, 0, 1, -1, -32768,
                   32767, -32768, 32767, 0, -23456, 23456, 0, 0};

    // every input known from time zero
    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.data   <= '0;
    cfg_we         <= 1'b0;
    cfg_addr       <= '0;
    cfg_wdata      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // warm-up spans a whole line so no delayed read lands on an unwritten entry
    program_regs(20'd49152, 20'd882, 20'd459, 20'd252000, 20'd2047);

    // directed: full-scale swings, steps of one code, zero, mid values
    for (int i = 0; i < 16; i++) begin
      pair.left_in  = 16'(left_vals[i]);
      pair.right_in = 16'(right_vals[i]);
      send_pair(pair);
    end
    // long enough to pass the warm-up and fill the line, feedback starts inside
    run_pairs(600);
    drain_unit();

    // full feedback (wide write masked to the gain width), shortest delay, two-point period
    program_regs(20'hfffff, 20'd1, 20'd0, 20'd2, 20'd0);
    run_pairs(150);
    drain_unit();

    // no feedback, longest base delay with a steep sweep so the delay clamps at the top
    program_regs(20'd0, 20'd2047, 20'd65535, 20'hfffff, 20'd0);
    run_pairs(150);
    drain_unit();

    // upper bits dropped on narrow registers, period of zero, longest warm-up
    program_regs(20'hf8000, 20'hffc05, 20'h12345, 20'd0, 20'hfffff);
    run_pairs(150);
    drain_unit();

    // moderate sweep; runs the phase well up the period
    program_regs(20'd40000, 20'd100, 20'd30000, 20'd5000, 20'd1);
    run_pairs(300);
    drain_unit();

    // period dropped below the running phase, zero base delay so the delay floor is hit
    program_regs(20'd20000, 20'd0, 20'd65535, 20'd300, 20'd0);
    run_pairs(150);
    drain_unit();

    // random settings, short periods favoured so the sweep turns round often
    repeat (2) begin
      program_regs(CFG_DATA_W'($urandom_range(0, 65535)),
                   CFG_DATA_W'($urandom_range(0, 2047)),
                   CFG_DATA_W'($urandom_range(0, 65535)),
                   ($urandom_range(0, 1) == 0) ? CFG_DATA_W'($urandom_range(0, 4000))
                                               : CFG_DATA_W'($urandom_range(0, 1048575)),
                   CFG_DATA_W'($urandom_range(0, 3000)));
      run_pairs(100);
      drain_unit();
    end

    // quiet tail, then anything still expected is a failure
    repeat (4 * ITEM_CYCLES) @(posedge clk);
    if (board.expected_pairs.size() != 0) begin
      board.fault_count += board.expected_pairs.size();
      $display("%0d expected output items never arrived", board.expected_pairs.size());
    end

    if (board.fault_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sff_pkg.sv
hw/rtl/sff_chan_if.sv
hw/rtl/sff_ram.sv
hw/rtl/sff_mul.sv
hw/rtl/stereo_feedback_flanger_unit.sv
bench/tb_stereo_feedback_flanger_unit.sv
